// ===== hdl/bba_pkg.sv =====
package bba_pkg;

  // Field and register widths
  localparam int CFG_W = 13;
  localparam int BLK_IN_W = 12;
  localparam int CMD_W = 2;
  localparam int ST_W = 2;

  // Default size of the map and reset value of the block count
  localparam int MAX_BLOCKS_DEF = 4096;
  localparam logic [CFG_W-1:0] COUNT_RST = CFG_W'(4096);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RANGE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIRST = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK = 2'd0;
  localparam logic [ST_W-1:0] ST_OCCUPIED = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

  // Source of the data written into a map byte
  typedef enum logic [1:0] {
    WR_ZERO,
    WR_RANGE,
    WR_FIRST
  } wr_sel_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic rewind;
    logic step;
    logic wr_en;
    wr_sel_t wr_sel;
    logic done;
    logic [ST_W-1:0] done_status;
    logic number_valid;
  } ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic query_bad;
    logic range_bad;
    logic none_free;
    logic hit;
    logic found;
    logic last;
    logic clear_last;
  } stat_t;

  // Bits of a map byte that belong to block offsets lo_off..hi_off.
  // Offset 0 is the most significant bit.
  function automatic logic [7:0] range_mask(input logic [2:0] lo_off,
                                            input logic [2:0] hi_off);
    logic [7:0] m;
    m = '0;
    for (int p = 0; p < 8; p++) begin
      m[7-p] = (3'(p) >= lo_off) && (3'(p) <= hi_off);
    end
    return m;
  endfunction

  // Lowest eligible free offset in a byte: {found, offset}.
  function automatic logic [3:0] first_free(input logic [7:0] map_byte,
                                            input logic [7:0] mask);
    logic [3:0] r;
    r = '0;
    for (int p = 7; p >= 0; p--) begin
      if (mask[7-p] && !map_byte[7-p]) begin
        r = {1'b1, 3'(p)};
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/bba_ctrl.sv =====
module bba_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bba_pkg::CMD_W-1:0]   in_command,
  input  bba_pkg::stat_t              stat,
  output bba_pkg::ctl_t               ctl,
  output logic                        busy
);
  import bba_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_QUERY,
    S_RCHK,
    S_RMARK,
    S_FSCAN
  } state_t;

  state_t state_r, state_nxt;
  logic busy_r, busy_nxt;

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    ctl.wr_sel = WR_ZERO;
    case (state_r)
      S_CLEAR: begin
        ctl.wr_en = 1'b1;
        ctl.wr_sel = WR_ZERO;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end else begin
          ctl.step = 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          case (in_command)
            CMD_QUERY: begin
              if (stat.query_bad) begin
                ctl.done = 1'b1;
                ctl.done_status = ST_RANGE;
              end else begin
                state_nxt = S_QUERY;
              end
            end
            CMD_RANGE: begin
              if (stat.range_bad) begin
                ctl.done = 1'b1;
                ctl.done_status = ST_RANGE;
              end else begin
                state_nxt = S_RCHK;
              end
            end
            CMD_FIRST: begin
              if (stat.none_free) begin
                ctl.done = 1'b1;
                ctl.done_status = ST_FULL;
              end else begin
                state_nxt = S_FSCAN;
              end
            end
            default: begin
              ctl.done = 1'b1;
              ctl.done_status = ST_RANGE;
            end
          endcase
        end
      end
      S_QUERY: begin
        ctl.done = 1'b1;
        ctl.done_status = stat.hit ? ST_OCCUPIED : ST_OK;
        state_nxt = S_IDLE;
      end
      S_RCHK: begin
        // First pass: any used block in the range aborts the transaction.
        if (stat.hit) begin
          ctl.done = 1'b1;
          ctl.done_status = ST_OCCUPIED;
          state_nxt = S_IDLE;
        end else if (stat.last) begin
          ctl.rewind = 1'b1;
          state_nxt = S_RMARK;
        end else begin
          ctl.step = 1'b1;
        end
      end
      S_RMARK: begin
        // Second pass: mark every block of the range used.
        ctl.wr_en = 1'b1;
        ctl.wr_sel = WR_RANGE;
        if (stat.last) begin
          ctl.done = 1'b1;
          ctl.done_status = ST_OK;
          state_nxt = S_IDLE;
        end else begin
          ctl.step = 1'b1;
        end
      end
      S_FSCAN: begin
        if (stat.found) begin
          ctl.wr_en = 1'b1;
          ctl.wr_sel = WR_FIRST;
          ctl.done = 1'b1;
          ctl.done_status = ST_OK;
          ctl.number_valid = 1'b1;
          state_nxt = S_IDLE;
        end else if (stat.last) begin
          ctl.done = 1'b1;
          ctl.done_status = ST_FULL;
          state_nxt = S_IDLE;
        end else begin
          ctl.step = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy_nxt = (state_nxt != S_IDLE);

  // State and registered busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      busy_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule

// ===== hdl/bba_dp.sv =====
module bba_dp #(
  parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [bba_pkg::CMD_W-1:0]      in_command,
  input  logic [bba_pkg::BLK_IN_W-1:0]   in_first_block,
  input  logic [bba_pkg::BLK_IN_W-1:0]   in_last_block,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bba_pkg::CFG_W-1:0]      cfg_data,
  input  bba_pkg::ctl_t                  ctl,
  output bba_pkg::stat_t                 stat,
  output logic                           out_valid,
  output logic [bba_pkg::ST_W-1:0]       out_status,
  output logic [bba_pkg::BLK_IN_W-1:0]   out_block_number
);
  import bba_pkg::*;

  localparam int MAP_BYTES = (MAX_BLOCKS + 7) / 8;
  localparam int ADDR_W = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam bit CAP = MAX_BLOCKS < (1 << CFG_W);
  localparam logic [CFG_W-1:0] CAP_VAL = CAP ? CFG_W'(MAX_BLOCKS) : '1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_BYTES - 1);

  logic [7:0] mem [MAP_BYTES];
  logic [7:0] rdata_r;
  logic [CFG_W-1:0] count_r;
  logic [CFG_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt, end_r;
  logic out_valid_r;
  logic [ST_W-1:0] out_status_r;
  logic [BLK_IN_W-1:0] out_number_r;

  logic [CFG_W-1:0] cnt;
  logic [CFG_W-1:0] first_ext, last_ext;
  logic [2:0] lo_off, hi_off;
  logic [7:0] mask;
  logic [3:0] ff;
  logic [7:0] wdata;
  logic [BLK_IN_W-1:0] blk_num;

  // The configuration register is always writable.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RST;
    end else if (cfg_valid) begin
      count_r <= cfg_data;
    end
  end

  // Effective block count and early checks on the incoming transaction
  assign cnt = (CAP && (count_r > CAP_VAL)) ? CAP_VAL : count_r;
  assign first_ext = CFG_W'(in_first_block);
  assign last_ext = CFG_W'(in_last_block);
  assign stat.query_bad = first_ext >= cnt;
  assign stat.range_bad = (first_ext > last_ext) || (last_ext >= cnt);
  assign stat.none_free = cnt <= CFG_W'(1);

  // Block range of the transaction
  always_comb begin
    case (in_command)
      CMD_FIRST: begin
        lo_nxt = CFG_W'(1);
        hi_nxt = cnt - CFG_W'(1);
      end
      CMD_RANGE: begin
        lo_nxt = first_ext;
        hi_nxt = last_ext;
      end
      default: begin
        lo_nxt = first_ext;
        hi_nxt = first_ext;
      end
    endcase
  end

  // Byte address walk; the read always targets the next address.
  always_comb begin
    if (ctl.load) begin
      addr_nxt = ADDR_W'(lo_nxt >> 3);
    end else if (ctl.rewind) begin
      addr_nxt = ADDR_W'(lo_r >> 3);
    end else if (ctl.step) begin
      addr_nxt = addr_r + ADDR_W'(1);
    end else begin
      addr_nxt = addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
    end else begin
      addr_r <= addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
      end_r <= ADDR_W'(hi_nxt >> 3);
    end
  end

  // Blocks of the current byte that lie inside the range
  assign lo_off = (addr_r == ADDR_W'(lo_r >> 3)) ? lo_r[2:0] : 3'd0;
  assign hi_off = (addr_r == end_r) ? hi_r[2:0] : 3'd7;
  assign mask = range_mask(lo_off, hi_off);
  assign ff = first_free(rdata_r, mask);
  assign blk_num = BLK_IN_W'({addr_r, ff[2:0]});

  assign stat.hit = (rdata_r & mask) != 8'd0;
  assign stat.found = ff[3];
  assign stat.last = addr_r == end_r;
  assign stat.clear_last = addr_r == LAST_ADDR;

  // Data written back into the map
  always_comb begin
    case (ctl.wr_sel)
      WR_RANGE: wdata = rdata_r | mask;
      WR_FIRST: wdata = rdata_r | (8'h80 >> ff[2:0]);
      default:  wdata = 8'h00;
    endcase
  end

  // Free map: one write port at the current address, registered read
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr_r] <= wdata;
    end
    rdata_r <= mem[addr_nxt];
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.done;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.done) begin
      out_status_r <= ctl.done_status;
      out_number_r <= ctl.number_valid ? blk_num : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_block_number = out_number_r;

endmodule

// ===== hdl/block_bitmap_allocator.sv =====
// Bitmap block allocator: one bit per block, 1 = used, lowest block in the
// most significant bit of each map byte.
// Input channel: a transaction (in_command, in_first_block, in_last_block)
// is taken on a clock edge with start high and busy low. Commands are query
// one block, allocate a range, and allocate the lowest free block above 0.
// Result channel: out_valid is high for exactly one cycle with out_status
// and out_block_number; the receiver cannot stall it.
// Configuration: cfg_data loads the block count when cfg_valid is high;
// cfg_ready is always high. Write it only while the block is idle.
// A rejected command gives its result without leaving idle; a query reads
// its one map byte; a range is checked byte by byte up to its first used
// block and, if none is used, walked again to mark every block; a first-free
// search reads map bytes until it finds a free block (at most ceil(count/8)
// bytes). The map is walked one byte per cycle; busy is already low in the
// strobe cycle, so the next transaction can be taken at the edge that ends it.
// Reset: the map is cleared by a pass over all (MAX_BLOCKS+7)/8 bytes, 512
// by default, with busy high; the block count resets to 4096.
module block_bitmap_allocator #(
  parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [bba_pkg::CMD_W-1:0]      in_command,
  input  logic [bba_pkg::BLK_IN_W-1:0]   in_first_block,
  input  logic [bba_pkg::BLK_IN_W-1:0]   in_last_block,
  output logic                           out_valid,
  output logic [bba_pkg::ST_W-1:0]       out_status,
  output logic [bba_pkg::BLK_IN_W-1:0]   out_block_number,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bba_pkg::CFG_W-1:0]      cfg_data
);
  import bba_pkg::*;

  ctl_t ctl;
  stat_t stat;

  // Sequencer
  bba_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .stat       (stat),
    .ctl        (ctl),
    .busy       (busy)
  );

  // Map memory, address walk and result registers
  bba_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_command       (in_command),
    .in_first_block   (in_first_block),
    .in_last_block    (in_last_block),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .ctl              (ctl),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_block_number (out_block_number)
  );

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import bba_pkg::*;

  localparam int MAP_BLOCKS = MAX_BLOCKS_DEF;
  localparam int MAP_BYTES = (MAP_BLOCKS + 7) / 8;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 8_000_000;
  localparam int TAIL_CYCLES = 20;
  localparam int RANDOM_ITEMS = 1750;
  localparam int PHASES = 12;

  typedef struct packed {
    logic [ST_W-1:0]     status;
    logic [BLK_IN_W-1:0] number;
  } outcome_t;

  // Tracks the used-block map and block count, predicts the outcome of each
  // accepted command and compares it with what the block returns.
  class block_map_tracker;
    bit [7:0] used_map [MAP_BYTES];
    logic [CFG_W-1:0] block_count;
    outcome_t expected_outcomes [$];
    int failures;

    function new();
      foreach (used_map[i]) used_map[i] = '0;
      block_count = COUNT_RST;
      failures = 0;
    endfunction

    function void set_block_count(logic [CFG_W-1:0] value);
      block_count = value;
    endfunction

    // Count of blocks that are actually managed, capped at the map size.
    function int managed();
      return (int'(block_count) > MAP_BLOCKS) ? MAP_BLOCKS : int'(block_count);
    endfunction

    // The lowest block of each byte lives in its most significant bit.
    function bit is_used(int b);
      return used_map[b / 8][7 - (b % 8)];
    endfunction

    function void mark_used(int b);
      used_map[b / 8][7 - (b % 8)] = 1'b1;
    endfunction

    function int pending();
      return expected_outcomes.size();
    endfunction

    // Work out the result of one accepted command and update the map.
    function void note_command(logic [CMD_W-1:0] cmd, logic [BLK_IN_W-1:0] first,
                               logic [BLK_IN_W-1:0] last);
      int cnt;
      int lo;
      int hi;
      bit clash;
      outcome_t res;
      cnt = managed();
      lo = int'(first);
      hi = int'(last);
      res.status = ST_RANGE;
      res.number = '0;
      case (cmd)
        CMD_QUERY: begin
          if (lo < cnt) res.status = is_used(lo) ? ST_OCCUPIED : ST_OK;
        end
        CMD_RANGE: begin
          if (lo <= hi && hi < cnt) begin
            clash = 1'b0;
            for (int b = lo; b <= hi; b++) begin
              if (is_used(b)) clash = 1'b1;
            end
            if (clash) begin
              res.status = ST_OCCUPIED;
            end else begin
              res.status = ST_OK;
              for (int b = lo; b <= hi; b++) mark_used(b);
            end
          end
        end
        CMD_FIRST: begin
          // Block 0 is never handed out by the first-free search.
          res.status = ST_FULL;
          for (int b = 1; b < cnt; b++) begin
            if (!is_used(b)) begin
              mark_used(b);
              res.status = ST_OK;
              res.number = BLK_IN_W'(b);
              break;
            end
          end
        end
        default: begin
        end
      endcase
      expected_outcomes.push_back(res);
    endfunction

    // Compare one returned result with the oldest prediction.
    function void check_result(logic [ST_W-1:0] status, logic [BLK_IN_W-1:0] number);
      outcome_t exp_res;
      if (expected_outcomes.size() == 0) begin
        $error("unexpected result: status %0d block_number %0d", status, number);
        failures++;
        return;
      end
      exp_res = expected_outcomes.pop_front();
      if (status !== exp_res.status) begin
        $error("status: expected %0d, got %0d", exp_res.status, status);
        failures++;
      end
      if (number !== exp_res.number) begin
        $error("block_number: expected %0d, got %0d", exp_res.number, number);
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic [CMD_W-1:0] in_command;
  logic [BLK_IN_W-1:0] in_first_block;
  logic [BLK_IN_W-1:0] in_last_block;
  logic out_valid;
  logic [ST_W-1:0] out_status;
  logic [BLK_IN_W-1:0] out_block_number;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data;
  int cycle_count = 0;

  block_map_tracker alloc_map = new();

  always #5 clk = ~clk;

  block_bitmap_allocator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_first_block   (in_first_block),
    .in_last_block    (in_last_block),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_block_number (out_block_number),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  // Every strobed result is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      alloc_map.check_result(out_status, out_block_number);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Send one command transaction after an optional idle gap. Returns at the
  // accepting edge with start still high.
  task automatic issue(logic [CMD_W-1:0] cmd, logic [BLK_IN_W-1:0] first,
                       logic [BLK_IN_W-1:0] last, int gap);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_first_block <= first;
    in_last_block <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    alloc_map.note_command(cmd, first, last);
  endtask

  // Hold off until every predicted result has arrived and the block is idle.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (alloc_map.pending() != 0 || busy) @(negedge clk);
  endtask

  // Write the block count while the block is idle.
  task automatic write_count(logic [CFG_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    alloc_map.set_block_count(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Number of idle cycles before the next transaction, given the percentage
  // of cycles in which the sender stays idle.
  function automatic int idle_gap(int idle_pct);
    int g;
    g = 0;
    while (g < 40 && $urandom_range(99) < idle_pct) g++;
    return g;
  endfunction

  // Random command, mostly aimed at managed blocks with short ranges.
  function automatic void pick_command(input int cnt, output logic [CMD_W-1:0] cmd,
                                       output logic [BLK_IN_W-1:0] first,
                                       output logic [BLK_IN_W-1:0] last);
    int r;
    int len;
    int lo;
    r = $urandom_range(99);
    first = BLK_IN_W'($urandom);
    last = BLK_IN_W'($urandom);
    if (r < 35) begin
      cmd = CMD_QUERY;
      if (cnt > 0 && $urandom_range(99) < 85) first = BLK_IN_W'($urandom_range(cnt - 1, 0));
    end else if (r < 65) begin
      cmd = CMD_RANGE;
      if (cnt > 0 && $urandom_range(99) < 80) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(15);
        lo = $urandom_range(cnt - 1, 0);
        first = BLK_IN_W'(lo);
        // Now and then let the range run past the managed count.
        if (lo + len >= cnt && $urandom_range(9) != 0) begin
          last = BLK_IN_W'(cnt - 1);
        end else begin
          last = BLK_IN_W'(lo + len);
        end
      end
    end else if (r < 95) begin
      cmd = CMD_FIRST;
    end else begin
      cmd = CMD_UNUSED;
    end
  endfunction

  // Directed commands: field extremes, every command and each special case.
  task automatic run_directed();
    issue(CMD_QUERY, 12'd0, 12'd0, 0);
    issue(CMD_QUERY, 12'd4095, 12'd4095, 0);
    issue(CMD_FIRST, 12'd0, 12'd0, 0);
    issue(CMD_RANGE, 12'd0, 12'd0, 0);
    issue(CMD_QUERY, 12'd0, 12'd0, 0);
    issue(CMD_RANGE, 12'd0, 12'd7, 0);
    issue(CMD_RANGE, 12'd4088, 12'd4095, 0);
    issue(CMD_RANGE, 12'd10, 12'd5, 0);
    issue(CMD_UNUSED, 12'd4095, 12'd4095, 0);
    issue(CMD_RANGE, 12'd16, 12'd23, 0);
    // A small map that can be filled completely.
    write_count(13'd9);
    issue(CMD_QUERY, 12'd9, 12'd0, 0);
    issue(CMD_RANGE, 12'd2, 12'd9, 0);
    issue(CMD_FIRST, 12'd0, 12'd0, 0);
    issue(CMD_RANGE, 12'd3, 12'd8, 0);
    issue(CMD_FIRST, 12'd0, 12'd0, 0);
    // No managed blocks at all.
    write_count(13'd0);
    issue(CMD_QUERY, 12'd0, 12'd0, 0);
    issue(CMD_FIRST, 12'd0, 12'd0, 0);
    issue(CMD_RANGE, 12'd0, 12'd0, 0);
    // A count above the map size is capped.
    write_count(13'd8191);
    issue(CMD_QUERY, 12'd4095, 12'd0, 0);
    issue(CMD_FIRST, 12'd0, 12'd0, 0);
    issue(CMD_RANGE, 12'd0, 12'd4095, 0);
  endtask

  initial begin
    logic [CFG_W-1:0] phase_counts [PHASES];
    int idle_pct;
    logic [CMD_W-1:0] cmd;
    logic [BLK_IN_W-1:0] first;
    logic [BLK_IN_W-1:0] last;

    phase_counts = '{13'd4096, 13'd1, 13'd8, 13'd8191, 13'd2, 13'd4095,
                     13'd0, 13'd64, 13'd4096, 13'd13, 13'd1000, 13'd4096};
    rst_n = 1'b0;
    start = 1'b0;
    in_command = CMD_QUERY;
    in_first_block = '0;
    in_last_block = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // The map clearing pass runs with busy high after reset.
    drain();
    run_directed();

    // Random phases, each with its own block count and sender idling.
    for (int p = 0; p < PHASES; p++) begin
      write_count(phase_counts[p]);
      case (p % 4)
        1: idle_pct = 78;
        3: idle_pct = 8;
        default: idle_pct = 0;
      endcase
      for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
        if ($urandom_range(199) == 0) drain();
        pick_command(alloc_map.managed(), cmd, first, last);
        issue(cmd, first, last, idle_gap(idle_pct));
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (alloc_map.failures == 0 && alloc_map.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
